// ----- hw/rtl/dram_latency_predictor_top_defines.svh -----
// Assertion macros shared by the DRAM latency predictor RTL.
`ifndef DRAM_LATENCY_PREDICTOR_TOP_DEFINES_SVH
`define DRAM_LATENCY_PREDICTOR_TOP_DEFINES_SVH

`define DLP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define DLP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/dlp_pkg.sv -----
// Types, constants and helper functions of the DRAM latency predictor.
package dlp_pkg;

   localparam int TW = 62;

   typedef logic signed [TW-1:0] time_type;

   localparam time_type TIME_LIMIT = 62'sh1000000000000000;
   localparam time_type IDLE_TIME  = -62'sd1000000000;
   localparam time_type OUT_MAX    = 62'sh3FFFFFFFFFFFF;
   localparam time_type OUT_MIN    = -62'sh4000000000000;

   localparam logic [2:0] REG_CMD_TO_DATA    = 3'd0;
   localparam logic [2:0] REG_ACTIVATE_TIME  = 3'd1;
   localparam logic [2:0] REG_PRECHARGE_COST = 3'd2;
   localparam logic [2:0] REG_BURST_LEN      = 3'd3;
   localparam logic [2:0] REG_READ_SPAN      = 3'd4;
   localparam logic [2:0] REG_WRITE_SPAN     = 3'd5;
   localparam logic [2:0] REG_SAME_BANK_GAP  = 3'd6;
   localparam logic [2:0] REG_FIXED_OFFSET   = 3'd7;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic           row_open;
      logic [15:0]    open_row;
      time_type       last_col;
      time_type       busy;
   } bank_entry_type;

   typedef struct packed {
      time_type       start;
      logic [8:0]     len;
   } cal_entry_type;

   typedef struct packed {
      logic           go;
      time_type       ready_time;
      logic [8:0]     len;
   } cal_req_type;

   typedef struct packed {
      logic           done;
      time_type       slot;
   } cal_rsp_type;

   function automatic time_type clamp_add(time_type a, logic signed [11:0] b);
      time_type s;
      s = a + TW'(b);
      if (s > TIME_LIMIT) begin
         s = TIME_LIMIT;
      end else if (s < -TIME_LIMIT) begin
         s = -TIME_LIMIT;
      end
      return s;
   endfunction

endpackage

// ----- hw/rtl/dlp_req_if.sv -----
// Access request channel and result channel interfaces.
interface dlp_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [32:0] address;
   logic [47:0] now_cycle;

   modport source (output valid, command, address, now_cycle, input ready);
   modport sink (input valid, command, address, now_cycle, output ready);
endinterface

interface dlp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [50:0] done_cycle;

   modport source (output valid, done_cycle, input ready);
   modport sink (input valid, done_cycle, output ready);
endinterface

// ----- hw/rtl/dram_latency_predictor_top.sv -----
// DRAM latency predictor top level: control sequencer and register port.
// Each request transfer on req carries a command (read or posted write), a
// 33-bit byte address and the arrival cycle; the block answers with exactly
// one rsp transfer holding the predicted completion cycle, in request order.
// Requests are handled one at a time: the bank number is registered, the
// bank entry is read, the ready time is formed, the calendar searches its
// stored reservations for a free window and inserts the new reservation in
// time order, the bank entry is written back and the result is loaded into
// the output register. The bank number comes from a reciprocal
// multiplication; the bank table and the calendar are memories with
// registered reads. A new request is taken as soon as the previous one
// has been placed in the output register, even while that result still
// waits; if the receiver stalls, the next result holds until rsp is free.
// Synchronous reset restores the register defaults, marks all banks closed
// and empties the calendar at once; no clearing pass is needed. The user
// must write the timing registers through the APB port only while the
// block is idle; the block itself does not enforce this.
`include "dram_latency_predictor_top_defines.svh"

module dram_latency_predictor_top
   import dlp_pkg::*;
#(
   parameter int NUM_BANKS      = 32,
   parameter int CALENDAR_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   dlp_req_if.sink     req,
   dlp_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int BW = $clog2(NUM_BANKS);
   localparam int MOD_SH = 21 + $clog2(NUM_BANKS);
   localparam longint unsigned MOD_RECIP =
      ((64'd1 << MOD_SH) + 64'(NUM_BANKS) - 64'd1) / 64'(NUM_BANKS);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MOD   = 4'd1;
   localparam logic [3:0] S_BRD   = 4'd2;
   localparam logic [3:0] S_BCALC = 4'd3;
   localparam logic [3:0] S_READY = 4'd4;
   localparam logic [3:0] S_CAL   = 4'd5;
   localparam logic [3:0] S_CWAIT = 4'd6;
   localparam logic [3:0] S_FIN1  = 4'd7;
   localparam logic [3:0] S_FIN2  = 4'd8;

   logic [8:0]        cmd_to_data_ff;
   logic [8:0]        activate_time_ff;
   logic [8:0]        precharge_cost_ff;
   logic [7:0]        burst_len_ff;
   logic [7:0]        read_span_ff;
   logic [8:0]        write_span_ff;
   logic [7:0]        same_bank_gap_ff;
   logic signed [8:0] fixed_offset_ff;

   logic [3:0]         state_ff, state_in;
   logic               cmd_ff, cmd_in;
   logic [32:0]        addr_ff, addr_in;
   time_type           now_ff, now_in;
   logic [BW-1:0]      rem_ff, rem_in;
   time_type           base_ff, base_in;
   logic [10:0]        add_ff, add_in;
   logic [8:0]         len_ff, len_in;
   time_type           ready_ff, ready_in;
   time_type           slot_ff, slot_in;
   time_type           busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [50:0] done_ff, done_in;

   logic [20:0]        bank_src;
   logic [MOD_SH+21:0] mod_prod;
   logic [20:0]        mod_quot;
   logic [27:0]        mod_diff;
   logic               wr_access;
   bank_entry_type     bank_rd;
   bank_entry_type     bank_wr;
   logic               bank_rd_en;
   logic               bank_wr_en;
   logic               row_hit;
   time_type           start_max;
   time_type           done_full;
   cal_req_type        cal_req;
   cal_rsp_type        cal_rsp;

   assign pready    = 1'b1;
   assign wr_access = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_to_data_ff    <= 9'd35;
         activate_time_ff  <= 9'd34;
         precharge_cost_ff <= 9'd33;
         burst_len_ff      <= 8'd8;
         read_span_ff      <= 8'd8;
         write_span_ff     <= 9'd14;
         same_bank_gap_ff  <= 8'd12;
         fixed_offset_ff   <= 9'sd0;
      end else if (wr_access) begin
         unique case (paddr[4:2])
            REG_CMD_TO_DATA:    cmd_to_data_ff    <= pwdata[8:0];
            REG_ACTIVATE_TIME:  activate_time_ff  <= pwdata[8:0];
            REG_PRECHARGE_COST: precharge_cost_ff <= pwdata[8:0];
            REG_BURST_LEN:      burst_len_ff      <= pwdata[7:0];
            REG_READ_SPAN:      read_span_ff      <= pwdata[7:0];
            REG_WRITE_SPAN:     write_span_ff     <= pwdata[8:0];
            REG_SAME_BANK_GAP:  same_bank_gap_ff  <= pwdata[7:0];
            REG_FIXED_OFFSET:   fixed_offset_ff   <= signed'(pwdata[8:0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_CMD_TO_DATA:    prdata = {23'b0, cmd_to_data_ff};
         REG_ACTIVATE_TIME:  prdata = {23'b0, activate_time_ff};
         REG_PRECHARGE_COST: prdata = {23'b0, precharge_cost_ff};
         REG_BURST_LEN:      prdata = {24'b0, burst_len_ff};
         REG_READ_SPAN:      prdata = {24'b0, read_span_ff};
         REG_WRITE_SPAN:     prdata = {23'b0, write_span_ff};
         REG_SAME_BANK_GAP:  prdata = {24'b0, same_bank_gap_ff};
         REG_FIXED_OFFSET:   prdata = {23'b0, fixed_offset_ff};
         default:            prdata = '0;
      endcase
   end

   dlp_bank_table #(
      .NUM_BANKS (NUM_BANKS)
   ) u_bank_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (bank_rd_en),
      .rd_bank (rem_ff),
      .rd_data (bank_rd),
      .wr_en   (bank_wr_en),
      .wr_bank (rem_ff),
      .wr_data (bank_wr)
   );

   dlp_calendar #(
      .DEPTH (CALENDAR_DEPTH)
   ) u_calendar (
      .clock   (clock),
      .reset   (reset),
      .cal_req (cal_req),
      .cal_rsp (cal_rsp)
   );

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.done_cycle = done_ff;

   assign row_hit   = bank_rd.row_open && (bank_rd.open_row == addr_ff[32:17]);
   assign start_max = (now_ff > base_ff) ? now_ff : base_ff;
   assign done_full = clamp_add(busy_ff, 12'(fixed_offset_ff));

   // The bank is address bits 32:12 modulo the bank count, found through an
   // exact reciprocal multiplication of the 21-bit value.
   assign bank_src = addr_ff[32:12];
   assign mod_prod = (MOD_SH+22)'(bank_src) * (MOD_SH+22)'(MOD_RECIP);
   assign mod_quot = mod_prod[MOD_SH+20:MOD_SH];
   assign mod_diff = 28'(bank_src) - 28'(mod_quot) * 28'(NUM_BANKS);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      now_in       = now_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      add_in       = add_ff;
      len_in       = len_ff;
      ready_in     = ready_ff;
      slot_in      = slot_ff;
      busy_in      = busy_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      bank_rd_en   = 1'b0;
      bank_wr_en   = 1'b0;
      bank_wr.row_open = 1'b1;
      bank_wr.open_row = addr_ff[32:17];
      bank_wr.last_col = (cmd_ff == CMD_WRITE) ? slot_ff :
                         clamp_add(slot_ff, -signed'({3'b000, cmd_to_data_ff}));
      bank_wr.busy     = clamp_add(slot_ff, signed'({4'b0000, burst_len_ff}));
      cal_req.go         = 1'b0;
      cal_req.ready_time = ready_ff;
      cal_req.len        = len_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in   = req.command;
               addr_in  = req.address;
               now_in   = signed'({14'b0, req.now_cycle});
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            rem_in   = mod_diff[BW-1:0];
            state_in = S_BRD;
         end
         S_BRD: begin
            bank_rd_en = 1'b1;
            state_in   = S_BCALC;
         end
         S_BCALC: begin
            if (cmd_ff == CMD_WRITE) begin
               base_in = now_ff;
               add_in  = '0;
               len_in  = write_span_ff;
            end else begin
               len_in = {1'b0, read_span_ff};
               if (row_hit) begin
                  base_in = clamp_add(bank_rd.last_col,
                                      signed'({4'b0000, same_bank_gap_ff}));
                  add_in  = {2'b00, cmd_to_data_ff};
               end else begin
                  base_in = (now_ff > bank_rd.busy) ? now_ff : bank_rd.busy;
                  add_in  = (bank_rd.row_open ? {2'b00, precharge_cost_ff} : 11'd0)
                          + {2'b00, activate_time_ff} + {2'b00, cmd_to_data_ff};
               end
            end
            state_in = S_READY;
         end
         S_READY: begin
            ready_in = clamp_add(start_max, signed'({1'b0, add_ff}));
            state_in = S_CAL;
         end
         S_CAL: begin
            cal_req.go = 1'b1;
            state_in   = S_CWAIT;
         end
         S_CWAIT: begin
            if (cal_rsp.done) begin
               slot_in  = cal_rsp.slot;
               state_in = S_FIN1;
            end
         end
         S_FIN1: begin
            bank_wr_en = 1'b1;
            busy_in    = bank_wr.busy;
            state_in   = S_FIN2;
         end
         S_FIN2: begin
            if (!rsp_valid_ff || rsp.ready) begin
               if (done_full > OUT_MAX) begin
                  done_in = OUT_MAX[50:0];
               end else if (done_full < OUT_MIN) begin
                  done_in = OUT_MIN[50:0];
               end else begin
                  done_in = done_full[50:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      now_ff   <= now_in;
      rem_ff   <= rem_in;
      base_ff  <= base_in;
      add_ff   <= add_in;
      len_ff   <= len_in;
      ready_ff <= ready_in;
      slot_ff  <= slot_in;
      busy_ff  <= busy_in;
      done_ff  <= done_in;
   end

   `DLP_ASSERT_NEXT(a_accept_starts, req.valid && req.ready, state_ff == S_MOD, "request transfer did not start bank decode")
   `DLP_ASSERT_SAME(a_cal_done_wait, cal_rsp.done, state_ff == S_CWAIT, "calendar finished outside wait")
   `DLP_ASSERT_NEXT(a_result_loaded, (state_ff == S_FIN2) && (!rsp_valid_ff || rsp.ready), rsp_valid_ff, "result not loaded into output register")

endmodule

// ----- hw/rtl/dlp_bank_table.sv -----
// Per-bank open-row and timing memory with reset valid bits.
module dlp_bank_table
   import dlp_pkg::*;
#(
   parameter int NUM_BANKS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(NUM_BANKS)-1:0] rd_bank,
   output bank_entry_type               rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(NUM_BANKS)-1:0] wr_bank,
   input  bank_entry_type               wr_data
);

   bank_entry_type       mem [NUM_BANKS];
   bank_entry_type       rdata_ff;
   logic                 rvalid_ff;
   logic [NUM_BANKS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_bank] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_bank];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_bank];
         end
         if (wr_en) begin
            valid_ff[wr_bank] <= 1'b1;
         end
      end
   end

   always_comb begin
      if (rvalid_ff) begin
         rd_data = rdata_ff;
      end else begin
         rd_data.row_open = 1'b0;
         rd_data.open_row = '0;
         rd_data.last_col = '0;
         rd_data.busy     = IDLE_TIME;
      end
   end

endmodule

// ----- hw/rtl/dlp_calendar.sv -----
// Time-sorted bus reservation calendar kept in a circular memory.
module dlp_calendar
   import dlp_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  cal_req_type cal_req,
   output cal_rsp_type cal_rsp
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_WALK = 2'd1;
   localparam logic [1:0] C_INS  = 2'd2;
   localparam logic [1:0] C_CMP  = 2'd3;

   cal_entry_type mem [DEPTH];
   cal_entry_type rdata_ff;

   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          dv_ff, dv_in;
   logic          done_ff, done_in;
   time_type      t_ff, t_in;
   logic [8:0]    len_ff, len_in;

   logic          rd_en;
   logic [PW-1:0] rd_addr;
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   cal_entry_type wr_data;
   cal_entry_type new_entry;
   time_type      e_end;
   time_type      t_end;
   logic [CW-1:0] cnt_after;

   function automatic logic [PW-1:0] phys(logic [PW-1:0] head, logic [CW-1:0] x);
      logic [PW:0] s;
      s = {1'b0, head} + (PW+1)'(x);
      if (s >= (PW+1)'(DEPTH)) begin
         s = s - (PW+1)'(DEPTH);
      end
      return s[PW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      dv_in     = 1'b0;
      done_in   = 1'b0;
      t_in      = t_ff;
      len_in    = len_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      new_entry.start = t_ff;
      new_entry.len   = len_ff;
      wr_data   = new_entry;
      e_end     = clamp_add(rdata_ff.start, signed'({3'b000, rdata_ff.len}));
      t_end     = clamp_add(t_ff, signed'({3'b000, len_ff}));
      cnt_after = count_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (cal_req.go) begin
               t_in     = cal_req.ready_time;
               len_in   = cal_req.len;
               idx_in   = '0;
               state_in = C_WALK;
            end
         end
         C_WALK: begin
            if (dv_ff && t_ff < e_end && t_end > rdata_ff.start) begin
               t_in = e_end;
            end
            if (idx_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = phys(head_ff, idx_ff);
               idx_in  = idx_ff + 1'b1;
               dv_in   = 1'b1;
            end else if (!dv_ff) begin
               if (count_ff == CW'(DEPTH)) begin
                  head_in   = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  cnt_after = CW'(DEPTH - 1);
               end
               count_in = cnt_after;
               pos_in   = cnt_after;
               state_in = C_INS;
            end
         end
         C_INS: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = phys(head_ff, '0);
               count_in = count_ff + 1'b1;
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, pos_ff - 1'b1);
               state_in = C_CMP;
            end
         end
         C_CMP: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, pos_ff);
            if (rdata_ff.start > t_ff) begin
               wr_data = rdata_ff;
               pos_in  = pos_ff - 1'b1;
               if (pos_ff == CW'(1)) begin
                  state_in = C_INS;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = phys(head_ff, pos_ff - CW'(2));
               end
            end else begin
               count_in = count_ff + 1'b1;
               done_in  = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         dv_ff    <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         dv_ff    <= dv_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      t_ff   <= t_in;
      len_ff <= len_in;
   end

   assign cal_rsp.done = done_ff;
   assign cal_rsp.slot = t_ff;

endmodule
